### hw/rtl/cpcsat_pkg.sv
package cpcsat_pkg;

  // vertex store size and derived widths
  localparam int MaxVertices = 16;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);

  // fixed-point widths
  localparam int CoordW    = 24;
  localparam int VtxW      = 2 * CoordW;
  localparam int EdgeW     = CoordW + 1;
  localparam int AxisW     = 32;
  localparam int ProdW     = AxisW + EdgeW;
  localparam int ProjW     = ProdW;
  localparam int OvW       = ProjW + 1;
  localparam int LsqW      = 52;
  localparam int LenW      = 26;
  localparam int QuotW     = 31;
  localparam int StepW     = 5;
  localparam int SqrtSteps = 26;
  localparam int DivSteps  = QuotW;
  localparam int QueueDepth = 2;
  localparam int QPtrW     = $clog2(QueueDepth);
  localparam int QCntW     = $clog2(QueueDepth + 1);

  localparam logic [LsqW-1:0] SqrtBit0 = LsqW'(1) << (2 * (SqrtSteps - 1));
  localparam logic signed [OvW-1:0] OvMax = {1'b0, {(OvW - 1){1'b1}}};

  typedef struct packed {
    logic                     which_shape;
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } in_word_t;

  typedef struct packed {
    logic                    collided;
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic                    too_many_vertices;
  } out_word_t;

  // test command handed from the loader to the engine
  typedef struct packed {
    logic [CntW-1:0] n1;
    logic [CntW-1:0] n2;
    logic            trunc;
  } cmd_t;

  // vertex store write port
  typedef struct packed {
    logic             we1;
    logic             we2;
    logic [AddrW-1:0] addr;
    logic [VtxW-1:0]  data;
  } store_wr_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_START,
    B_EDGE_A,
    B_EDGE_B,
    B_EDGE_D,
    B_SQ_X,
    B_SQ_Y,
    B_SQ_SUM,
    B_SQRT,
    B_DIV,
    B_PRJ_RD,
    B_PRJ_X,
    B_PRJ_Y,
    B_PRJ_ACC,
    B_OVL,
    B_NEXT,
    B_PASS_END,
    B_OUT
  } back_state_e;

endpackage

### hw/rtl/cpcsat_ram.sv
module cpcsat_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/cpcsat_queue.sv
module cpcsat_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpcsat_pkg::cmd_t  cmd_i,
  input  logic              pop_i,
  output cpcsat_pkg::cmd_t  cmd_o,
  output logic              not_empty_o,
  output logic              full_o
);

  cpcsat_pkg::cmd_t                   slot_q [cpcsat_pkg::QueueDepth];
  logic [cpcsat_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [cpcsat_pkg::QCntW-1:0]       cnt_q;
  logic                               do_push, do_pop;

  assign full_o      = (cnt_q == cpcsat_pkg::QCntW'(cpcsat_pkg::QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  // payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### hw/rtl/cpcsat_front.sv
module cpcsat_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpcsat_pkg::in_word_t  in_data_i,
  output cpcsat_pkg::store_wr_t wr_o,
  output logic                  push_o,
  output cpcsat_pkg::cmd_t      cmd_o,
  input  logic                  q_full_i,
  input  logic                  done_i
);

  logic [cpcsat_pkg::CntW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d, n1_base;
  logic                        trunc_q, trunc_d, closed_q, closed_d, busy_q, busy_d;
  logic                        accept;

  assign in_stall_o = busy_q | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign n1_base    = closed_q ? '0 : cnt1_q;

  // vertex classification and store write
  always_comb begin
    cnt1_d   = cnt1_q;
    cnt2_d   = cnt2_q;
    trunc_d  = trunc_q;
    closed_d = closed_q;
    busy_d   = busy_q;
    push_o   = 1'b0;
    wr_o     = '0;
    wr_o.data = {in_data_i.vertex_x, in_data_i.vertex_y};
    cmd_o    = '0;
    if (done_i) busy_d = 1'b0;
    if (accept) begin
      if (!in_data_i.which_shape) begin
        wr_o.addr = n1_base[cpcsat_pkg::AddrW-1:0];
        if (n1_base < cpcsat_pkg::CntW'(cpcsat_pkg::MaxVertices)) begin
          wr_o.we1 = 1'b1;
          cnt1_d   = n1_base + 1'b1;
        end else begin
          cnt1_d  = n1_base;
          trunc_d = 1'b1;
        end
        closed_d = in_data_i.last_vertex;
      end else begin
        wr_o.addr = cnt2_q[cpcsat_pkg::AddrW-1:0];
        if (cnt2_q < cpcsat_pkg::CntW'(cpcsat_pkg::MaxVertices)) begin
          wr_o.we2 = 1'b1;
          cnt2_d   = cnt2_q + 1'b1;
        end else begin
          trunc_d = 1'b1;
        end
        // last vertex of the second polygon starts a test
        if (in_data_i.last_vertex) begin
          push_o      = 1'b1;
          cmd_o.n1    = cnt1_q;
          cmd_o.n2    = cnt2_d;
          cmd_o.trunc = trunc_d;
          cnt1_d      = '0;
          cnt2_d      = '0;
          trunc_d     = 1'b0;
          closed_d    = 1'b0;
          busy_d      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q   <= '0;
      cnt2_q   <= '0;
      trunc_q  <= 1'b0;
      closed_q <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      cnt1_q   <= cnt1_d;
      cnt2_q   <= cnt2_d;
      trunc_q  <= trunc_d;
      closed_q <= closed_d;
      busy_q   <= busy_d;
    end
  end

endmodule

### hw/rtl/cpcsat_back.sv
module cpcsat_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  cpcsat_pkg::cmd_t                    cmd_i,
  output logic                                cmd_pop_o,
  output logic [cpcsat_pkg::AddrW-1:0]        rd_addr_o,
  input  logic [cpcsat_pkg::VtxW-1:0]         rd_data1_i,
  input  logic [cpcsat_pkg::VtxW-1:0]         rd_data2_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cpcsat_pkg::out_word_t               out_data_o,
  output logic                                done_o
);

  cpcsat_pkg::back_state_e state_q, state_d;
  cpcsat_pkg::cmd_t        cmd_q;
  cpcsat_pkg::out_word_t   out_q;

  logic                                k_q, prj_b_q, first_q, div_y_q, sign_q, sel_q, sel_d;
  logic [cpcsat_pkg::AddrW-1:0]        i_q, j_q, nx;
  logic [cpcsat_pkg::StepW-1:0]        step_q;
  logic [cpcsat_pkg::CntW-1:0]         na, nb, nj;
  logic signed [cpcsat_pkg::CoordW-1:0] pix_q, piy_q, vy_q, rd_x, rd_y;
  logic signed [cpcsat_pkg::EdgeW-1:0] ax_q, ay_q, ax_d, ay_d;
  logic [cpcsat_pkg::EdgeW-1:0]        mag_x, mag_y;
  logic signed [cpcsat_pkg::AxisW-1:0] mul_a, ux_q, uy_q, bax_q, bay_q, b0x_q, b0y_q, qsig;
  logic signed [cpcsat_pkg::EdgeW-1:0] mul_b;
  logic signed [cpcsat_pkg::ProdW-1:0] prod_d, prod_q, px_q;
  logic signed [cpcsat_pkg::ProjW-1:0] d_val, hi_q, lo_q, amx_q, amn_q, min_hi, max_lo;
  logic signed [cpcsat_pkg::OvW-1:0]   ov, best_q, best0_q;
  logic [cpcsat_pkg::LsqW-1:0]         lsq_q, v_q, res_q, bit_q, sq_sum, v_n, res_n;
  logic [cpcsat_pkg::LenW-1:0]         len_q, rem_q, rem_n;
  logic [cpcsat_pkg::LenW:0]           dv_t, dv_diff;
  logic [cpcsat_pkg::QuotW-1:0]        dvd_q, quo_q, quo_n;
  logic                                sq_ge, dv_ge, edge_zero, ov_fail, i_last, j_last;
  logic                                sqrt_last, div_last;

  // polygon roles of the current pass
  assign na = k_q ? cmd_q.n2 : cmd_q.n1;
  assign nb = k_q ? cmd_q.n1 : cmd_q.n2;
  assign nj = prj_b_q ? nb : na;
  assign i_last = ({1'b0, i_q} == na - 1'b1);
  assign j_last = ({1'b0, j_q} == nj - 1'b1);
  assign nx     = i_last ? '0 : i_q + 1'b1;
  assign {rd_x, rd_y} = sel_q ? rd_data2_i : rd_data1_i;

  // edge normal from the two endpoints
  assign ax_d = {rd_y[cpcsat_pkg::CoordW-1], rd_y} - {piy_q[cpcsat_pkg::CoordW-1], piy_q};
  assign ay_d = {pix_q[cpcsat_pkg::CoordW-1], pix_q} - {rd_x[cpcsat_pkg::CoordW-1], rd_x};
  assign edge_zero = (ax_d == '0) && (ay_d == '0);
  assign mag_x = ax_q[cpcsat_pkg::EdgeW-1] ? -ax_q : ax_q;
  assign mag_y = ay_q[cpcsat_pkg::EdgeW-1] ? -ay_q : ay_q;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      cpcsat_pkg::B_SQ_X: begin
        mul_a = {{(cpcsat_pkg::AxisW - cpcsat_pkg::EdgeW){ax_q[cpcsat_pkg::EdgeW-1]}}, ax_q};
        mul_b = ax_q;
      end
      cpcsat_pkg::B_SQ_Y: begin
        mul_a = {{(cpcsat_pkg::AxisW - cpcsat_pkg::EdgeW){ay_q[cpcsat_pkg::EdgeW-1]}}, ay_q};
        mul_b = ay_q;
      end
      cpcsat_pkg::B_PRJ_X: begin
        mul_a = ux_q;
        mul_b = {rd_x[cpcsat_pkg::CoordW-1], rd_x};
      end
      cpcsat_pkg::B_PRJ_Y: begin
        mul_a = uy_q;
        mul_b = {vy_q[cpcsat_pkg::CoordW-1], vy_q};
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // one square-root step
  assign sq_sum    = res_q + bit_q;
  assign sq_ge     = (v_q >= sq_sum);
  assign v_n       = sq_ge ? v_q - sq_sum : v_q;
  assign res_n     = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;
  assign sqrt_last = (step_q == cpcsat_pkg::StepW'(cpcsat_pkg::SqrtSteps - 1));

  // one restoring division step
  assign dv_t     = {rem_q, dvd_q[cpcsat_pkg::QuotW-1]};
  assign dv_ge    = (dv_t >= {1'b0, len_q});
  assign dv_diff  = dv_t - {1'b0, len_q};
  assign rem_n    = dv_ge ? dv_diff[cpcsat_pkg::LenW-1:0] : dv_t[cpcsat_pkg::LenW-1:0];
  assign quo_n    = {quo_q[cpcsat_pkg::QuotW-2:0], dv_ge};
  assign div_last = (step_q == cpcsat_pkg::StepW'(cpcsat_pkg::DivSteps - 1));
  assign qsig     = sign_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});

  // projection and overlap
  assign d_val  = px_q + prod_q;
  assign min_hi = (amx_q < hi_q) ? amx_q : hi_q;
  assign max_lo = (amn_q > lo_q) ? amn_q : lo_q;
  assign ov     = {min_hi[cpcsat_pkg::ProjW-1], min_hi} - {max_lo[cpcsat_pkg::ProjW-1], max_lo};
  assign ov_fail = ov[cpcsat_pkg::OvW-1] || (ov == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpcsat_pkg::B_IDLE:     if (cmd_valid_i) state_d = cpcsat_pkg::B_START;
      cpcsat_pkg::B_START: begin
        if (cmd_q.n1 == '0 || cmd_q.n2 == '0) state_d = cpcsat_pkg::B_OUT;
        else state_d = cpcsat_pkg::B_EDGE_A;
      end
      cpcsat_pkg::B_EDGE_A:   state_d = cpcsat_pkg::B_EDGE_B;
      cpcsat_pkg::B_EDGE_B:   state_d = cpcsat_pkg::B_EDGE_D;
      cpcsat_pkg::B_EDGE_D:   state_d = edge_zero ? cpcsat_pkg::B_NEXT : cpcsat_pkg::B_SQ_X;
      cpcsat_pkg::B_SQ_X:     state_d = cpcsat_pkg::B_SQ_Y;
      cpcsat_pkg::B_SQ_Y:     state_d = cpcsat_pkg::B_SQ_SUM;
      cpcsat_pkg::B_SQ_SUM:   state_d = cpcsat_pkg::B_SQRT;
      cpcsat_pkg::B_SQRT:     if (sqrt_last) state_d = cpcsat_pkg::B_DIV;
      cpcsat_pkg::B_DIV:      if (div_last && div_y_q) state_d = cpcsat_pkg::B_PRJ_RD;
      cpcsat_pkg::B_PRJ_RD:   state_d = cpcsat_pkg::B_PRJ_X;
      cpcsat_pkg::B_PRJ_X:    state_d = cpcsat_pkg::B_PRJ_Y;
      cpcsat_pkg::B_PRJ_Y:    state_d = cpcsat_pkg::B_PRJ_ACC;
      cpcsat_pkg::B_PRJ_ACC:  state_d = (j_last && prj_b_q) ? cpcsat_pkg::B_OVL
                                                            : cpcsat_pkg::B_PRJ_RD;
      cpcsat_pkg::B_OVL:      state_d = ov_fail ? cpcsat_pkg::B_OUT : cpcsat_pkg::B_NEXT;
      cpcsat_pkg::B_NEXT:     state_d = i_last ? cpcsat_pkg::B_PASS_END : cpcsat_pkg::B_EDGE_A;
      cpcsat_pkg::B_PASS_END: state_d = k_q ? cpcsat_pkg::B_OUT : cpcsat_pkg::B_EDGE_A;
      cpcsat_pkg::B_OUT:      if (!out_stall_i) state_d = cpcsat_pkg::B_IDLE;
      default:                state_d = cpcsat_pkg::B_IDLE;
    endcase
  end

  // outputs and store read port
  always_comb begin
    cmd_pop_o   = (state_q == cpcsat_pkg::B_IDLE) && cmd_valid_i;
    out_valid_o = (state_q == cpcsat_pkg::B_OUT);
    done_o      = out_valid_o && !out_stall_i;
    out_data_o  = out_q;
    rd_addr_o   = '0;
    sel_d       = k_q;
    unique case (state_q)
      cpcsat_pkg::B_EDGE_A: rd_addr_o = i_q;
      cpcsat_pkg::B_EDGE_B: rd_addr_o = nx;
      cpcsat_pkg::B_PRJ_RD: begin
        rd_addr_o = j_q;
        sel_d     = k_q ^ prj_b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpcsat_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    prod_q <= prod_d;
    unique case (state_q)
      cpcsat_pkg::B_IDLE: begin
        cmd_q <= cmd_i;
      end
      cpcsat_pkg::B_START: begin
        k_q    <= 1'b0;
        i_q    <= '0;
        best_q <= cpcsat_pkg::OvMax;
        bax_q  <= '0;
        bay_q  <= '0;
        out_q.collided          <= 1'b0;
        out_q.axis_x            <= '0;
        out_q.axis_y            <= '0;
        out_q.too_many_vertices <= cmd_q.trunc;
      end
      cpcsat_pkg::B_EDGE_B: begin
        pix_q <= rd_x;
        piy_q <= rd_y;
      end
      cpcsat_pkg::B_EDGE_D: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
      end
      cpcsat_pkg::B_SQ_Y: begin
        lsq_q <= prod_q[cpcsat_pkg::LsqW-1:0];
      end
      cpcsat_pkg::B_SQ_SUM: begin
        v_q    <= lsq_q + prod_q[cpcsat_pkg::LsqW-1:0];
        res_q  <= '0;
        bit_q  <= cpcsat_pkg::SqrtBit0;
        step_q <= '0;
      end
      cpcsat_pkg::B_SQRT: begin
        v_q    <= v_n;
        res_q  <= res_n;
        bit_q  <= bit_q >> 2;
        if (sqrt_last) begin
          // start dividing the x component
          len_q   <= res_n[cpcsat_pkg::LenW-1:0];
          div_y_q <= 1'b0;
          sign_q  <= ax_q[cpcsat_pkg::EdgeW-1];
          rem_q   <= cpcsat_pkg::LenW'(mag_x >> 1);
          dvd_q   <= {mag_x[0], {(cpcsat_pkg::QuotW - 1){1'b0}}};
          quo_q   <= '0;
          step_q  <= '0;
        end else begin
          step_q  <= step_q + 1'b1;
        end
      end
      cpcsat_pkg::B_DIV: begin
        if (div_last && !div_y_q) begin
          // x done, start dividing the y component
          ux_q    <= qsig;
          div_y_q <= 1'b1;
          sign_q  <= ay_q[cpcsat_pkg::EdgeW-1];
          rem_q   <= cpcsat_pkg::LenW'(mag_y >> 1);
          dvd_q   <= {mag_y[0], {(cpcsat_pkg::QuotW - 1){1'b0}}};
          quo_q   <= '0;
          step_q  <= '0;
        end else begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          dvd_q  <= dvd_q << 1;
          step_q <= step_q + 1'b1;
          if (div_last) begin
            uy_q    <= qsig;
            j_q     <= '0;
            prj_b_q <= 1'b0;
            first_q <= 1'b1;
          end
        end
      end
      cpcsat_pkg::B_PRJ_X: begin
        vy_q <= rd_y;
      end
      cpcsat_pkg::B_PRJ_Y: begin
        px_q <= prod_q;
      end
      cpcsat_pkg::B_PRJ_ACC: begin
        // running extremes of one polygon
        if (first_q || d_val > hi_q) hi_q <= d_val;
        if (first_q || d_val < lo_q) lo_q <= d_val;
        if (j_last) begin
          j_q     <= '0;
          first_q <= !prj_b_q;
          if (!prj_b_q) begin
            amx_q   <= (first_q || d_val > hi_q) ? d_val : hi_q;
            amn_q   <= (first_q || d_val < lo_q) ? d_val : lo_q;
            prj_b_q <= 1'b1;
          end
        end else begin
          j_q     <= j_q + 1'b1;
          first_q <= 1'b0;
        end
      end
      cpcsat_pkg::B_OVL: begin
        if (ov_fail) begin
          out_q.collided <= 1'b0;
          out_q.axis_x   <= bax_q;
          out_q.axis_y   <= bay_q;
        end else if (ov < best_q) begin
          best_q <= ov;
          bax_q  <= ux_q;
          bay_q  <= uy_q;
        end
      end
      cpcsat_pkg::B_NEXT: begin
        i_q <= nx;
      end
      cpcsat_pkg::B_PASS_END: begin
        if (!k_q) begin
          best0_q <= best_q;
          b0x_q   <= bax_q;
          b0y_q   <= bay_q;
          k_q     <= 1'b1;
          i_q     <= '0;
          best_q  <= cpcsat_pkg::OvMax;
          bax_q   <= '0;
          bay_q   <= '0;
        end else begin
          // both passes overlap: smaller minimum wins, tie to second pass
          out_q.collided <= 1'b1;
          if (best0_q < best_q) begin
            out_q.axis_x <= b0x_q;
            out_q.axis_y <= b0y_q;
          end else begin
            out_q.axis_x <= bax_q;
            out_q.axis_y <= bay_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/convex_polygon_collision_sat.sv
// vertex load: one vertex a cycle while in_stall_o is low, no result
// test: one result per last vertex of the second polygon; after the start state, each
// non-degenerate edge goes through edge setup, squaring, a 26-step square root (one result
// bit a cycle), two 31-step divisions and a projection of each of the n1 + n2 vertices
// input stalls from the test vertex until its result is taken
// reset clears counts, flags and engine state; vertex stores are not cleared
module convex_polygon_collision_sat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpcsat_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cpcsat_pkg::out_word_t out_data_o
);

  cpcsat_pkg::store_wr_t           wr;
  cpcsat_pkg::cmd_t                push_cmd, head_cmd;
  logic                            push, pop, q_not_empty, q_full, done;
  logic [cpcsat_pkg::AddrW-1:0]    rd_addr;
  logic [cpcsat_pkg::VtxW-1:0]     rd_data1, rd_data2;

  // loader
  cpcsat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .wr_o       (wr),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_full_i   (q_full),
    .done_i     (done)
  );

  // vertex stores
  cpcsat_ram #(
    .Width (cpcsat_pkg::VtxW),
    .Depth (cpcsat_pkg::MaxVertices)
  ) u_store1 (
    .clk_i   (clk_i),
    .we_i    (wr.we1),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data1)
  );

  cpcsat_ram #(
    .Width (cpcsat_pkg::VtxW),
    .Depth (cpcsat_pkg::MaxVertices)
  ) u_store2 (
    .clk_i   (clk_i),
    .we_i    (wr.we2),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data2)
  );

  // test command queue
  cpcsat_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (push_cmd),
    .pop_i       (pop),
    .cmd_o       (head_cmd),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  // separating-axis engine
  cpcsat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_not_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .rd_addr_o   (rd_addr),
    .rd_data1_i  (rd_data1),
    .rd_data2_i  (rd_data2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .done_o      (done)
  );

endmodule
